// ===== rtl/core/mma_pkg.sv =====
// Shared types and constants for the Montgomery modular ALU (P = 104857601).
// Used by mma_ctrl, mma_dp and montgomery_mod_alu; depends on nothing.
`timescale 1ns / 1ps

package mma_pkg;

  localparam logic [31:0] MOD_P      = 32'd104857601;
  localparam logic [31:0] MOD_2P     = 32'd209715202;
  localparam logic [26:0] EXP_INV    = 27'd104857599;  // P - 2
  localparam logic [26:0] EXP_MOD    = 27'd104857600;  // P - 1 = 25 * 2^22
  localparam logic [31:0] MONT_NINV  = 32'd104857599;  // -1/P mod 2^32
  localparam logic [31:0] MONT_R2    = 32'd45971250;   // 2^64 mod P
  localparam logic [31:0] MONT_ONE   = 32'd100663256;  // 2^32 mod P
  localparam int          EXP_STEPS  = 21;             // 42 high bits, two per step
  localparam int          CNT_W      = $clog2(EXP_STEPS);

  typedef enum logic [3:0] {
    KIND_TOMONT   = 4'd0,
    KIND_FROMMONT = 4'd1,
    KIND_ADD      = 4'd2,
    KIND_SUB      = 4'd3,
    KIND_MUL      = 4'd4,
    KIND_LAZYNEG  = 4'd5,
    KIND_PLAINNEG = 4'd6,
    KIND_POW      = 4'd7,
    KIND_INV      = 4'd8,
    KIND_DIV      = 4'd9
  } kind_t;

  typedef enum logic [1:0] {XS_A, XS_ACC, XS_BASE} xsel_t;
  typedef enum logic [2:0] {YS_B, YS_BASE, YS_ACC, YS_R2, YS_ONE} ysel_t;
  typedef enum logic [1:0] {DS_RES, DS_ACC, DS_BASE} dest_t;

  typedef struct packed {
    logic  load;
    logic  ex_step;
    logic  ex_fix;
    logic  shift_e;
    logic  issue;
    xsel_t xsel;
    ysel_t ysel;
    dest_t dest;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  pipe_busy;
    logic  e_zero;
    logic  e_bit0;
  } sts_t;

endpackage

// ===== rtl/core/montgomery_mod_alu.sv =====
// Top level of the Montgomery modular ALU for P = 104857601.
// Depends on mma_pkg, mma_ctrl and mma_dp.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low; its result appears on
// result for one cycle with done high, and the receiver must take it then.
// Add, sub, both negates and unused kinds finish straight from dispatch. Tomont,
// frommont and mul issue one multiply on the four-stage Montgomery multiply pipe
// and wait for it to drain. Power, inverse and divide run square-and-multiply on
// that pipe LSB first, one exponent bit per square; power first reduces the
// exponent mod P-1, and divide ends with one more multiply.
module montgomery_mod_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  input  logic signed [63:0] exponent,
  output logic               done,
  output logic [31:0]        result
);

  mma_pkg::cmd_t cmd;
  mma_pkg::sts_t sts;

  mma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mma_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (kind),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .exponent  (exponent),
    .result    (result)
  );

endmodule

// ===== rtl/core/mma_ctrl.sv =====
// Sequencer for the Montgomery ALU: dispatch, exponent reduction, square-and-multiply.
// Depends on mma_pkg; drives mma_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module mma_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mma_pkg::sts_t sts,
  output mma_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EXP_STEP,
    ST_EXP_FIX,
    ST_POW_SQ,
    ST_POW_MUL,
    ST_POW_WAIT,
    ST_ISSUE,
    ST_FINAL_WAIT,
    ST_FINISH
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [mma_pkg::CNT_W-1:0] cnt;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.xsel   = mma_pkg::XS_A;
    cmd.ysel   = mma_pkg::YS_B;
    cmd.dest   = mma_pkg::DS_RES;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.kind)
          mma_pkg::KIND_TOMONT, mma_pkg::KIND_FROMMONT, mma_pkg::KIND_MUL:
            state_next = ST_ISSUE;
          mma_pkg::KIND_POW:
            state_next = ST_EXP_STEP;
          mma_pkg::KIND_INV, mma_pkg::KIND_DIV:
            state_next = ST_POW_SQ;
          default:
            state_next = ST_FINISH;
        endcase
      end
      ST_EXP_STEP: begin
        cmd.ex_step = 1'b1;
        if (cnt == mma_pkg::CNT_W'(mma_pkg::EXP_STEPS - 1)) begin
          state_next = ST_EXP_FIX;
        end
      end
      ST_EXP_FIX: begin
        cmd.ex_fix = 1'b1;
        state_next = ST_POW_SQ;
      end
      ST_POW_SQ: begin
        if (sts.e_zero) begin
          state_next = (sts.kind == mma_pkg::KIND_DIV) ? ST_ISSUE : ST_FINISH;
        end else begin
          // base squared; the multiply below still reads the old base
          cmd.issue  = 1'b1;
          cmd.xsel   = mma_pkg::XS_BASE;
          cmd.ysel   = mma_pkg::YS_BASE;
          cmd.dest   = mma_pkg::DS_BASE;
          state_next = ST_POW_MUL;
        end
      end
      ST_POW_MUL: begin
        cmd.issue   = sts.e_bit0;
        cmd.xsel    = mma_pkg::XS_ACC;
        cmd.ysel    = mma_pkg::YS_BASE;
        cmd.dest    = mma_pkg::DS_ACC;
        cmd.shift_e = 1'b1;
        state_next  = ST_POW_WAIT;
      end
      ST_POW_WAIT: begin
        if (!sts.pipe_busy) begin
          state_next = ST_POW_SQ;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        cmd.dest  = mma_pkg::DS_RES;
        case (sts.kind)
          mma_pkg::KIND_TOMONT:   cmd.ysel = mma_pkg::YS_R2;
          mma_pkg::KIND_FROMMONT: cmd.ysel = mma_pkg::YS_ONE;
          mma_pkg::KIND_DIV:      cmd.ysel = mma_pkg::YS_ACC;
          default:                cmd.ysel = mma_pkg::YS_B;
        endcase
        state_next = ST_FINAL_WAIT;
      end
      ST_FINAL_WAIT: begin
        if (!sts.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
      if (cmd.ex_step) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_single : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted word did not make the unit busy");
  a_finish_drained : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.pipe_busy)
    else $error("result taken while multiplier pipe still in flight");
  a_issue_busy : assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> busy)
    else $error("multiply issued while idle");
`endif

endmodule

// ===== rtl/core/mma_dp.sv =====
// Datapath of the Montgomery ALU: operand registers, 4-stage Montgomery multiply pipe,
// exponent reduction mod P-1 and the result register. Depends on mma_pkg.
`timescale 1ns / 1ps

module mma_dp (
  input  logic               clk,
  input  logic               rst,
  input  mma_pkg::cmd_t      cmd,
  output mma_pkg::sts_t      sts,
  input  logic [3:0]         kind,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  input  logic signed [63:0] exponent,
  output logic [31:0]        result
);

  // value < 100 reduced mod 25
  function automatic logic [4:0] mod25(input logic [6:0] v);
    logic [6:0] r;
    begin
      if (v >= 7'd75)      r = v - 7'd75;
      else if (v >= 7'd50) r = v - 7'd50;
      else if (v >= 7'd25) r = v - 7'd25;
      else                 r = v;
      mod25 = r[4:0];
    end
  endfunction

  mma_pkg::kind_t kind_q;
  logic [31:0]    a_q;
  logic [31:0]    b_q;
  logic [31:0]    acc;
  logic [31:0]    base;
  logic [31:0]    res;
  logic [26:0]    e;

  // exponent reduction: P-1 = 25 << 22, so only the top 42 bits need mod 25
  logic [63:0]    ex_raw;
  logic [63:0]    ex_mag;
  logic [41:0]    ex_hi;
  logic [21:0]    ex_lo;
  logic           ex_neg;
  logic [4:0]     ex_rem;
  logic [26:0]    ex_val;

  // Montgomery pipe
  logic [31:0]    mx;
  logic [31:0]    my;
  logic           v1, v2, v3;
  mma_pkg::dest_t d1, d2, d3;
  logic [63:0]    t1, t2, t3;
  logic [31:0]    q2;
  logic [58:0]    qp3;
  logic [63:0]    red_sum;
  logic [31:0]    red_out;

  logic [31:0]    add_s, sub_s, out_value;

  assign ex_raw = exponent;
  assign ex_mag = exponent[63] ? (~ex_raw + 64'd1) : ex_raw;
  assign ex_val = {ex_rem, ex_lo};

  always_comb begin
    case (cmd.xsel)
      mma_pkg::XS_ACC:  mx = acc;
      mma_pkg::XS_BASE: mx = base;
      default:          mx = a_q;
    endcase
    case (cmd.ysel)
      mma_pkg::YS_BASE: my = base;
      mma_pkg::YS_ACC:  my = acc;
      mma_pkg::YS_R2:   my = mma_pkg::MONT_R2;
      mma_pkg::YS_ONE:  my = 32'd1;
      default:          my = b_q;
    endcase
  end

  assign red_sum = t3 + {5'd0, qp3};
  assign red_out = red_sum[63:32];

  assign sts.kind      = kind_q;
  assign sts.pipe_busy = v1 | v2 | v3;
  assign sts.e_zero    = (e == '0);
  assign sts.e_bit0    = e[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    // pipe payload
    t1  <= {32'd0, mx} * {32'd0, my};
    d1  <= cmd.dest;
    t2  <= t1;
    q2  <= t1[31:0] * mma_pkg::MONT_NINV;
    d2  <= d1;
    t3  <= t2;
    qp3 <= {27'd0, q2} * {32'd0, mma_pkg::MOD_P[26:0]};
    d3  <= d2;

    if (cmd.load) begin
      kind_q <= mma_pkg::kind_t'(kind);
      a_q    <= operand_a;
      b_q    <= operand_b;
      acc    <= mma_pkg::MONT_ONE;
      base   <= (mma_pkg::kind_t'(kind) == mma_pkg::KIND_DIV) ? operand_b : operand_a;
      e      <= mma_pkg::EXP_INV;
      ex_neg <= exponent[63];
      ex_hi  <= ex_mag[63:22];
      ex_lo  <= ex_mag[21:0];
      ex_rem <= '0;
    end else begin
      if (cmd.ex_step) begin
        ex_rem <= mod25({ex_rem, ex_hi[41:40]});
        ex_hi  <= {ex_hi[39:0], 2'b00};
      end
      if (cmd.ex_fix) begin
        e <= (ex_neg && ex_val != '0) ? (mma_pkg::EXP_MOD - ex_val) : ex_val;
      end else if (cmd.shift_e) begin
        e <= {1'b0, e[26:1]};
      end
      if (v3) begin
        case (d3)
          mma_pkg::DS_ACC:  acc  <= red_out;
          mma_pkg::DS_BASE: base <= red_out;
          default:          res  <= red_out;
        endcase
      end
    end
  end

  assign add_s = a_q + (b_q - mma_pkg::MOD_2P);
  assign sub_s = a_q - b_q;

  always_comb begin
    case (kind_q)
      mma_pkg::KIND_FROMMONT: out_value = (res >= mma_pkg::MOD_P) ? res - mma_pkg::MOD_P : res;
      mma_pkg::KIND_ADD:      out_value = add_s[31] ? add_s + mma_pkg::MOD_2P : add_s;
      mma_pkg::KIND_SUB:      out_value = sub_s[31] ? sub_s + mma_pkg::MOD_2P : sub_s;
      mma_pkg::KIND_LAZYNEG:  out_value = (a_q == '0) ? '0 : mma_pkg::MOD_2P - a_q;
      mma_pkg::KIND_PLAINNEG: out_value = (a_q == '0) ? '0 : mma_pkg::MOD_P - a_q;
      mma_pkg::KIND_POW, mma_pkg::KIND_INV:
                              out_value = acc;
      mma_pkg::KIND_TOMONT, mma_pkg::KIND_MUL, mma_pkg::KIND_DIV:
                              out_value = res;
      default:                out_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result <= out_value;
    end
  end

endmodule
